// ===== src/load_data_writeback_formatter_macros.svh =====
// ---------------------------------------------------------------------------
// Load data writeback formatter: assertion macros
// Concurrent check macros for implication and next-cycle properties.
// ---------------------------------------------------------------------------
`ifndef LOAD_DATA_WRITEBACK_FORMATTER_MACROS_SVH
`define LOAD_DATA_WRITEBACK_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define LDWF_ASSERT_SAME(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("ldwf check failed: same-cycle implication");
// Next-cycle implication, checked outside reset
`define LDWF_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("ldwf check failed: next-cycle implication");
`else
`define LDWF_ASSERT_SAME(label, clk, rst, lhs, rhs)
`define LDWF_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ===== src/ldwf_pkg.sv =====
// ---------------------------------------------------------------------------
// Load data writeback formatter package
// Item types, command codes and architecture levels shared by the block.
// ---------------------------------------------------------------------------
package ldwf_pkg;

   // Load command codes
   localparam logic [3:0] CMD_WORD       = 4'd0;
   localparam logic [3:0] CMD_USER_WORD  = 4'd1;
   localparam logic [3:0] CMD_MULTI_WORD = 4'd2;
   localparam logic [3:0] CMD_MULTI_PC   = 4'd3;
   localparam logic [3:0] CMD_RETURN_PC  = 4'd4;
   localparam logic [3:0] CMD_BYTE       = 4'd5;
   localparam logic [3:0] CMD_HALF       = 4'd6;
   localparam logic [3:0] CMD_SBYTE      = 4'd7;
   localparam logic [3:0] CMD_SHALF      = 4'd8;

   // Architecture levels
   localparam logic [1:0] ARCH_PRE_V4T = 2'd0;
   localparam logic [1:0] ARCH_V4T     = 2'd1;
   localparam logic [1:0] ARCH_V5      = 2'd2;

   localparam logic [3:0]  PC_REG         = 4'd15;
   localparam logic [31:0] MASK_INTERWORK = 32'hFFFF_FFFE;
   localparam logic [31:0] MASK_WORD      = 32'hFFFF_FFFC;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [1:0]  addr_low;
      logic [31:0] read_data;
      logic        read_failed;
      logic [2:0]  fault_code;
      logic [3:0]  dest_reg;
      logic        thumb_flag;
   } req_type;

   typedef struct packed {
      logic        aborted;
      logic [2:0]  abort_kind;
      logic        reg_we;
      logic [3:0]  reg_num;
      logic [31:0] reg_value;
      logic        pc_we;
      logic [31:0] pc_value;
      logic        t_we;
      logic        t_value;
      logic        unpredictable;
   } rsp_type;

endpackage

// ===== src/ldwf_req_reg.sv =====
// ---------------------------------------------------------------------------
// Load data writeback formatter: input register
// Captures one request item and holds it until the result stage takes it.
// ---------------------------------------------------------------------------
module ldwf_req_reg
   import ldwf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    hold_valid,
   input  logic    hold_take,
   output req_type hold_data
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   // Stall only while a held item cannot move on
   assign req_stall = valid_ff && !hold_take;

   // Load on accept, drop when taken
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_valid && !req_stall) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (hold_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign hold_valid = valid_ff;
   assign hold_data  = data_ff;

endmodule

// ===== src/ldwf_format.sv =====
// ---------------------------------------------------------------------------
// Load data writeback formatter: data formatting
// Rotates, extends and masks load data into register, PC and T-bit writes.
// ---------------------------------------------------------------------------
module ldwf_format
   import ldwf_pkg::*;
(
   input  logic [1:0] arch_level,
   input  req_type    item,
   output rsp_type    result
);

   logic        odd_half;
   logic        v5;
   logic [31:0] rotated;
   logic [31:0] value;
   logic        to_reg;

   assign odd_half = (item.cmd inside {CMD_HALF, CMD_SHALF}) && item.addr_low[0];
   assign v5       = (arch_level >= ARCH_V5);

   // Rotate right by whole bytes of the address
   always_comb begin
      case (item.addr_low)
         2'd0:    rotated = item.read_data;
         2'd1:    rotated = {item.read_data[7:0],  item.read_data[31:8]};
         2'd2:    rotated = {item.read_data[15:0], item.read_data[31:16]};
         default: rotated = {item.read_data[23:0], item.read_data[31:24]};
      endcase
   end

   // Build the writes for one item
   always_comb begin
      result = '0;
      value  = '0;
      to_reg = 1'b0;
      if (item.cmd > CMD_SHALF) begin
         // unknown command: write nothing
      end else if (item.read_failed && !odd_half) begin
         result.aborted    = 1'b1;
         result.abort_kind = item.fault_code;
      end else begin
         to_reg = 1'b1;
         case (item.cmd)
            CMD_WORD: begin
               value = rotated;
               if (item.dest_reg == PC_REG) begin
                  to_reg        = 1'b0;
                  result.pc_we  = 1'b1;
                  if (v5) begin
                     result.pc_value = rotated & MASK_INTERWORK;
                     result.t_we     = 1'b1;
                     result.t_value  = rotated[0];
                  end else begin
                     result.pc_value = rotated & MASK_WORD;
                  end
               end
            end
            CMD_USER_WORD: value = rotated;
            CMD_MULTI_WORD: value = item.read_data;
            CMD_MULTI_PC: begin
               to_reg       = 1'b0;
               result.pc_we = 1'b1;
               if (v5) begin
                  result.pc_value = item.read_data & MASK_INTERWORK;
                  result.t_we     = 1'b1;
                  result.t_value  = item.read_data[0];
               end else begin
                  result.pc_value = item.read_data & MASK_WORD;
               end
            end
            CMD_RETURN_PC: begin
               to_reg       = 1'b0;
               result.pc_we = 1'b1;
               if ((arch_level >= ARCH_V4T) && item.thumb_flag) begin
                  result.pc_value = item.read_data & MASK_INTERWORK;
               end else begin
                  result.pc_value = item.read_data & MASK_WORD;
               end
            end
            CMD_BYTE: value = {24'd0, item.read_data[7:0]};
            CMD_HALF: begin
               if (odd_half) begin
                  result.unpredictable = 1'b1;
               end else begin
                  value = {16'd0, item.read_data[15:0]};
               end
            end
            CMD_SBYTE: value = {{24{item.read_data[7]}}, item.read_data[7:0]};
            default: begin
               // signed halfword
               if (odd_half) begin
                  result.unpredictable = 1'b1;
               end else begin
                  value = {{16{item.read_data[15]}}, item.read_data[15:0]};
               end
            end
         endcase
         if (to_reg) begin
            result.reg_we    = 1'b1;
            result.reg_num   = item.dest_reg;
            result.reg_value = value;
         end
      end
   end

endmodule

// ===== src/ldwf_rsp_reg.sv =====
// ---------------------------------------------------------------------------
// Load data writeback formatter: result register
// Holds one formatted item on the result channel until it is taken.
// ---------------------------------------------------------------------------
module ldwf_rsp_reg
   import ldwf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fmt_valid,
   output logic    fmt_take,
   input  rsp_type fmt_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Take a new item when empty or when the held one leaves
   assign fmt_take = fmt_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (fmt_take) begin
         valid_in = 1'b1;
         data_in  = fmt_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/load_data_writeback_formatter.sv =====
// ---------------------------------------------------------------------------
// Load data writeback formatter
// Top level: input register, formatting logic, result register, CSR.
// ---------------------------------------------------------------------------
// Each load response item goes through an input register and a result
// register with the rotate, extend and PC-mask logic between them, so an item
// is captured in the input register when accepted and then passes to the result
// register, which presents it on the result channel; one item can be accepted
// every cycle, and throughput only drops when the result side stalls. The architecture level CSR
// (reset v5) is always ready and must be written only while the block is idle.
`include "load_data_writeback_formatter_macros.svh"

module load_data_writeback_formatter
   import ldwf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_wdata
);

   logic [1:0] arch_level_ff, arch_level_in;
   logic       hold_valid;
   logic       hold_take;
   req_type    hold_data;
   rsp_type    fmt_data;

   // Architecture level register
   assign csr_ready     = 1'b1;
   assign arch_level_in = (csr_valid && csr_ready) ? csr_wdata : arch_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_level_ff <= ARCH_V5;
      end else begin
         arch_level_ff <= arch_level_in;
      end
   end

   ldwf_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .hold_valid (hold_valid),
      .hold_take  (hold_take),
      .hold_data  (hold_data)
   );

   ldwf_format u_format (
      .arch_level (arch_level_ff),
      .item       (hold_data),
      .result     (fmt_data)
   );

   ldwf_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .fmt_valid (hold_valid),
      .fmt_take  (hold_take),
      .fmt_data  (fmt_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Checks
   `LDWF_ASSERT_SAME(a_abort_no_write, clock, reset,
      rsp_valid && rsp_data.aborted,
      !rsp_data.reg_we && !rsp_data.pc_we && !rsp_data.t_we)
   `LDWF_ASSERT_SAME(a_t_with_pc, clock, reset,
      rsp_valid && rsp_data.t_we,
      rsp_data.pc_we && !rsp_data.reg_we)
   `LDWF_ASSERT_SAME(a_unpred_zero, clock, reset,
      rsp_valid && rsp_data.unpredictable,
      rsp_data.reg_we && (rsp_data.reg_value == 32'd0) && !rsp_data.aborted)
   `LDWF_ASSERT_NEXT(a_held_moves, clock, reset, hold_valid && !rsp_valid, rsp_valid)

endmodule

// ===== verif/tb_load_data_writeback_formatter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Load data writeback formatter testbench
// Drives load responses through the formatter under random idling on both
// sides, predicts every writeback result and compares each field in order.
// Covers each architecture level, including the unassigned one.
// ---------------------------------------------------------------------------
module tb_load_data_writeback_formatter;
   import ldwf_pkg::*;

   // Commands outside the defined set
   localparam logic [3:0] CMD_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
   localparam logic [1:0] ARCH_SPARE     = 2'd3;
   localparam int         CYCLE_LIMIT    = 200000;
   localparam int         MAX_REPORTS    = 10;
   localparam int         SETTLE_CYCLES  = 8;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_wdata = '0;

   req_type    load_q[$];
   rsp_type    writeback_q[$];
   logic [1:0] arch_model = ARCH_V5;
   bit         req_fire   = 1'b0;
   bit         csr_fired  = 1'b0;
   bit         quiet      = 1'b0;
   int         send_gap   = 0;
   int         calm_send  = 0;
   int         stall_left = 0;
   int         calm_recv  = 0;
   int         cycle_count    = 0;
   int         n_queued       = 0;
   int         n_accepted     = 0;
   int         n_checked      = 0;
   int         n_aborts       = 0;
   int         n_pc_writes    = 0;
   int         n_odd_halves   = 0;
   int         mismatch_count = 0;

   load_data_writeback_formatter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Work out the register, PC and T-bit writes that one load response causes
   function automatic rsp_type predict_writeback(req_type ld, logic [1:0] level);
      rsp_type     wb;
      logic [63:0] doubled;
      logic [31:0] rotated;
      logic [31:0] val;
      logic [31:0] pc_src;
      logic        odd_half;
      logic        to_reg;
      logic        pc_load;
      wb       = '0;
      doubled  = {ld.read_data, ld.read_data} >> {ld.addr_low, 3'b000};
      rotated  = doubled[31:0];
      odd_half = (ld.cmd == CMD_HALF || ld.cmd == CMD_SHALF) && ld.addr_low[0];
      val      = '0;
      pc_src   = '0;
      to_reg   = 1'b1;
      pc_load  = 1'b0;
      if (ld.cmd > CMD_SHALF) begin
         // unknown command: no write, no abort
      end else if (ld.read_failed && !odd_half) begin
         wb.aborted    = 1'b1;
         wb.abort_kind = ld.fault_code;
      end else begin
         case (ld.cmd)
            CMD_WORD: begin
               val = rotated;
               if (ld.dest_reg == PC_REG) begin
                  to_reg  = 1'b0;
                  pc_load = 1'b1;
                  pc_src  = rotated;
               end
            end
            CMD_USER_WORD:  val = rotated;
            CMD_MULTI_WORD: val = ld.read_data;
            CMD_MULTI_PC: begin
               to_reg  = 1'b0;
               pc_load = 1'b1;
               pc_src  = ld.read_data;
            end
            CMD_RETURN_PC: begin
               to_reg      = 1'b0;
               wb.pc_we    = 1'b1;
               wb.pc_value = ld.read_data & ((level >= ARCH_V4T && ld.thumb_flag) ?
                                             MASK_INTERWORK : MASK_WORD);
            end
            CMD_BYTE:  val = {24'b0, ld.read_data[7:0]};
            CMD_HALF:  val = odd_half ? '0 : {16'b0, ld.read_data[15:0]};
            CMD_SBYTE: val = {{24{ld.read_data[7]}}, ld.read_data[7:0]};
            default:   val = odd_half ? '0 : {{16{ld.read_data[15]}}, ld.read_data[15:0]};
         endcase
         // Interworking load from v5 on; older cores drop the low two bits
         if (pc_load) begin
            wb.pc_we = 1'b1;
            if (level >= ARCH_V5) begin
               wb.pc_value = pc_src & MASK_INTERWORK;
               wb.t_we     = 1'b1;
               wb.t_value  = pc_src[0];
            end else begin
               wb.pc_value = pc_src & MASK_WORD;
            end
         end
         if (to_reg) begin
            wb.reg_we    = 1'b1;
            wb.reg_num   = ld.dest_reg;
            wb.reg_value = val;
         end
         wb.unpredictable = odd_half;
      end
      return wb;
   endfunction

   function automatic string format_writeback(rsp_type wb);
      return $sformatf("abort=%b kind=%0d reg_we=%b r%0d=%h pc_we=%b pc=%h t_we=%b t=%b unp=%b",
                       wb.aborted, wb.abort_kind, wb.reg_we, wb.reg_num, wb.reg_value,
                       wb.pc_we, wb.pc_value, wb.t_we, wb.t_value, wb.unpredictable);
   endfunction

   // Compare one result with the oldest expectation
   task automatic check_writeback(input rsp_type got);
      rsp_type want;
      if (writeback_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("cycle %0d: result with no load pending: %s",
                     cycle_count, format_writeback(got));
      end else begin
         want = writeback_q.pop_front();
         n_checked++;
         if (got.aborted !== want.aborted || got.abort_kind !== want.abort_kind ||
             got.reg_we !== want.reg_we || got.reg_num !== want.reg_num ||
             got.reg_value !== want.reg_value || got.pc_we !== want.pc_we ||
             got.pc_value !== want.pc_value || got.t_we !== want.t_we ||
             got.t_value !== want.t_value || got.unpredictable !== want.unpredictable) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("cycle %0d: writeback mismatch on result %0d", cycle_count, n_checked);
               $display("   expected %s", format_writeback(want));
               $display("   actual   %s", format_writeback(got));
            end
         end
      end
   endtask

   // Present queued loads; hold an item until taken, idle in random bursts
   always @(negedge clock) begin
      if (calm_send > 0)
         calm_send--;
      else if ($urandom_range(0, 40) == 0)
         calm_send = $urandom_range(20, 80);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold the stalled item
      end else if (send_gap > 0) begin
         send_gap--;
         req_valid <= 1'b0;
      end else if (load_q.size() == 0) begin
         req_valid <= 1'b0;
      end else if (!quiet && calm_send == 0 && $urandom_range(0, 5) == 0) begin
         send_gap = $urandom_range(0, 4);
         req_valid <= 1'b0;
      end else begin
         req_data  <= load_q.pop_front();
         req_valid <= 1'b1;
      end
   end

   // Stall the result side in random bursts
   always @(negedge clock) begin
      if (calm_recv > 0)
         calm_recv--;
      else if ($urandom_range(0, 40) == 0)
         calm_recv = $urandom_range(20, 80);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && !quiet && calm_recv == 0 && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Record accepted loads and register writes, check results
   always @(posedge clock) begin
      if (reset) begin
         arch_model = ARCH_V5;
         req_fire   = 1'b0;
         csr_fired  = 1'b0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, writeback_q.size());
         $display("tb_load_data_writeback_formatter: done, errors");
         $finish;
      end else begin
         cycle_count++;
         req_fire = req_valid && !req_stall;
         if (req_fire) begin
            writeback_q.push_back(predict_writeback(req_data, arch_model));
            n_accepted++;
            n_aborts     += writeback_q[$].aborted;
            n_pc_writes  += writeback_q[$].pc_we;
            n_odd_halves += writeback_q[$].unpredictable;
         end
         if (rsp_valid && !rsp_stall)
            check_writeback(rsp_data);
         csr_fired = csr_valid && csr_ready;
         if (csr_fired)
            arch_model = csr_wdata;
      end
   end

   task automatic queue_load(input logic [3:0] cmd, input logic [1:0] alow,
                             input logic [31:0] data, input logic failed,
                             input logic [2:0] fcode, input logic [3:0] dreg,
                             input logic tflag);
      req_type ld;
      ld.cmd         = cmd;
      ld.addr_low    = alow;
      ld.read_data   = data;
      ld.read_failed = failed;
      ld.fault_code  = fcode;
      ld.dest_reg    = dreg;
      ld.thumb_flag  = tflag;
      load_q.push_back(ld);
      n_queued++;
   endtask

   // Wait for every load to be taken and every result to come back
   task automatic drain_all();
      while (n_accepted != n_queued || writeback_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_arch_level(input logic [1:0] level);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= level;
      do
         @(negedge clock);
      while (!csr_fired);
      csr_valid <= 1'b0;
   endtask

   // Queue random loads, mostly defined commands with PC and sign-edge data
   task automatic queue_random_loads(input int count);
      logic [3:0]  cmd;
      logic [31:0] data;
      repeat (count) begin
         if ($urandom_range(0, 99) < 6)
            cmd = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
         else
            cmd = 4'($urandom_range(CMD_WORD, CMD_SHALF));
         case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = '1;
            2:       data = $urandom | 32'h8080_8080;
            3:       data = $urandom & 32'h7F7F_7F7F;
            default: data = $urandom;
         endcase
         queue_load(cmd, 2'($urandom_range(0, 3)), data, $urandom_range(0, 9) == 0,
                    3'($urandom_range(0, 7)),
                    ($urandom_range(0, 4) == 0) ? PC_REG : 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(input logic [1:0] level, input int count);
      drain_all();
      write_arch_level(level);
      @(posedge clock);
      queue_random_loads(count);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed loads at the reset architecture level
      queue_load(CMD_WORD,       2'd0, 32'h1234_5678, 1'b0, 3'd0, 4'd3,   1'b0);
      queue_load(CMD_WORD,       2'd1, 32'h8000_0103, 1'b0, 3'd0, PC_REG, 1'b0);
      queue_load(CMD_WORD,       2'd2, 32'hA5B6_C7D8, 1'b0, 3'd0, 4'd0,   1'b0);
      queue_load(CMD_WORD,       2'd3, 32'hFFFF_FFFF, 1'b0, 3'd0, PC_REG, 1'b1);
      queue_load(CMD_USER_WORD,  2'd3, 32'h0102_0304, 1'b0, 3'd0, PC_REG, 1'b0);
      queue_load(CMD_MULTI_WORD, 2'd2, 32'hDEAD_BEEF, 1'b0, 3'd0, PC_REG, 1'b0);
      queue_load(CMD_MULTI_PC,   2'd1, 32'h0000_1235, 1'b0, 3'd0, 4'd4,   1'b1);
      queue_load(CMD_RETURN_PC,  2'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, 4'd9,   1'b1);
      queue_load(CMD_RETURN_PC,  2'd3, 32'hFFFF_FFFF, 1'b0, 3'd0, 4'd9,   1'b0);
      queue_load(CMD_BYTE,       2'd1, 32'hFFFF_FF80, 1'b0, 3'd0, PC_REG, 1'b0);
      queue_load(CMD_HALF,       2'd0, 32'h0000_ABCD, 1'b0, 3'd0, 4'd7,   1'b0);
      queue_load(CMD_HALF,       2'd1, 32'hFFFF_FFFF, 1'b1, 3'd5, 4'd2,   1'b0);
      queue_load(CMD_HALF,       2'd3, 32'h1234_5678, 1'b0, 3'd0, 4'd1,   1'b0);
      queue_load(CMD_SBYTE,      2'd0, 32'h0000_0080, 1'b0, 3'd0, 4'd5,   1'b0);
      queue_load(CMD_SBYTE,      2'd2, 32'hFFFF_FF7F, 1'b0, 3'd0, 4'd6,   1'b0);
      queue_load(CMD_SHALF,      2'd2, 32'h0000_8000, 1'b0, 3'd0, 4'd8,   1'b0);
      queue_load(CMD_SHALF,      2'd0, 32'hFFFF_7FFF, 1'b0, 3'd0, PC_REG, 1'b0);
      queue_load(CMD_SHALF,      2'd3, 32'h0000_8000, 1'b1, 3'd7, 4'd10,  1'b0);
      queue_load(CMD_WORD,       2'd0, 32'h1234_5678, 1'b1, 3'd7, PC_REG, 1'b0);
      queue_load(CMD_BYTE,       2'd2, 32'hFFFF_FFFF, 1'b1, 3'd0, 4'd11,  1'b0);
      queue_load(CMD_UNKNOWN_LO, 2'd1, 32'hFFFF_FFFF, 1'b0, 3'd3, 4'd12,  1'b1);
      queue_load(CMD_UNKNOWN_HI, 2'd3, 32'hFFFF_FFFF, 1'b1, 3'd6, PC_REG, 1'b1);
      queue_load(CMD_HALF,       2'd2, 32'h0000_0000, 1'b0, 3'd0, 4'd0,   1'b0);

      // Random loads at each architecture level; the last phase runs without idling
      run_phase(ARCH_PRE_V4T, 300);
      run_phase(ARCH_V4T, 300);
      run_phase(ARCH_SPARE, 300);
      drain_all();
      quiet = 1'b1;
      run_phase(ARCH_V5, 350);
      drain_all();

      $display("covered %0d loads and %0d results across arch levels 2, 0, 1, 3, 2",
               n_accepted, n_checked);
      $display("including %0d aborts, %0d PC writes and %0d odd halfwords",
               n_aborts, n_pc_writes, n_odd_halves);
      if (mismatch_count == 0 && writeback_q.size() == 0)
         $display("tb_load_data_writeback_formatter: done, clean");
      else
         $display("tb_load_data_writeback_formatter: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/ldwf_pkg.sv
src/ldwf_req_reg.sv
src/ldwf_format.sv
src/ldwf_rsp_reg.sv
src/load_data_writeback_formatter.sv
verif/tb_load_data_writeback_formatter.sv
